/* hdl/cle_pkg.sv */
// shared constants and result type for the command line editor and matcher
`default_nettype none
package cle_pkg;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_ESC = 8'h1B;

    localparam logic [7:0] CH_H   = 8'h68;  // "h"
    localparam logic [7:0] CH_V   = 8'h76;  // "v"
    localparam logic [7:0] CH_E   = 8'h65;  // "e"
    localparam logic [7:0] CH_R   = 8'h72;  // "r"
    localparam logic [7:0] CH_0   = 8'h30;  // "0"
    localparam logic [7:0] CH_1   = 8'h31;  // "1"

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_HELP    = 3'd1;
    localparam logic [2:0] CMD_LED_OFF = 3'd2;
    localparam logic [2:0] CMD_LED_ON  = 3'd3;
    localparam logic [2:0] CMD_VERSION = 3'd4;
    localparam logic [2:0] CMD_UNKNOWN = 3'd5;

    // number of leading characters that the command texts look at
    localparam int HEAD_LEN = 3;

    localparam int RESULT_W = 12;
    localparam int TDATA_W  = 16;

    typedef struct packed {
        logic [2:0] command;
        logic       line_done;
        logic [7:0] echo_char;
    } cle_result_t;

endpackage
`default_nettype wire

/* hdl/cle_line.sv */
// line state: length counter, head characters and command matching
`default_nettype none
module cle_line #(
    parameter int LINE_CAPACITY = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               char_valid,
    input  wire logic [7:0]         rx_char,
    output cle_pkg::cle_result_t    result
);
    import cle_pkg::*;

    localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
    localparam logic [LEN_W-1:0] CAP  = LEN_W'(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] ONE  = LEN_W'(1);
    localparam logic [LEN_W-1:0] THREE = LEN_W'(3);
    localparam logic [LEN_W-1:0] HEAD = LEN_W'(HEAD_LEN);

    logic [LEN_W-1:0] length_reg, length_next;
    // only the first characters of a line can decide a match, the rest are counted
    logic [7:0]       head_reg [HEAD_LEN];
    logic             head_we;
    logic [1:0]       head_idx;
    logic [2:0]       code;

    always_comb begin
        if (length_reg == ONE && head_reg[0] == CH_H) begin
            code = CMD_HELP;
        end else if (length_reg == ONE && head_reg[0] == CH_0) begin
            code = CMD_LED_OFF;
        end else if (length_reg == ONE && head_reg[0] == CH_1) begin
            code = CMD_LED_ON;
        end else if (length_reg == THREE && head_reg[0] == CH_V && head_reg[1] == CH_E
                     && head_reg[2] == CH_R) begin
            code = CMD_VERSION;
        end else begin
            code = CMD_UNKNOWN;
        end
    end

    always_comb begin
        length_next      = length_reg;
        head_we          = 1'b0;
        head_idx         = length_reg[1:0];
        result.echo_char = rx_char;
        result.line_done = 1'b0;
        result.command   = CMD_NONE;
        if (rx_char == CH_ESC) begin
            length_next      = '0;
            result.line_done = 1'b1;
            result.command   = CMD_UNKNOWN;
        end else if (rx_char == CH_CR || rx_char == CH_LF) begin
            length_next      = '0;
            result.line_done = 1'b1;
            result.command   = code;
        end else if (rx_char == CH_BS || rx_char == CH_DEL) begin
            if (length_reg != '0) begin
                length_next = length_reg - ONE;
            end
        end else if (length_reg < CAP) begin
            length_next = length_reg + ONE;
            head_we     = (length_reg < HEAD);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= '0;
        end else if (char_valid) begin
            length_reg <= length_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (char_valid && head_we) begin
            head_reg[head_idx] <= rx_char;
        end
    end

endmodule
`default_nettype wire

/* hdl/cle_out_buf.sv */
// two-entry result buffer that decouples the input from the output stall
`default_nettype none
module cle_out_buf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  cle_pkg::cle_result_t    in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cle_pkg::cle_result_t    out_data
);
    import cle_pkg::*;

    cle_result_t entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

/* hdl/command_line_editor_and_matcher_top.sv */
// top level of the command line editor and matcher
`default_nettype none
// Takes one terminal character per request and returns one result per request:
// the echoed character, a line-done flag and a command code (0 none, 1 help "h",
// 2 led off "0" so send 0x30, 3 led on "1" so send 0x31, 4 version "ver",
// 5 unknown or empty line). Backspace and delete drop the last character,
// escape ends the line as an empty command, CR or LF end and match it.
// Characters beyond LINE_CAPACITY are echoed but not stored, erase on an empty
// line does nothing. One request is taken every cycle while the result buffer
// has room: the line state and the matching compares sit between the input
// handshake and a two-entry result buffer, which registers each result. The
// input keeps flowing while one result waits on the output and stalls only once
// two results wait, so an output stall reaches the input once both entries fill.
module command_line_editor_and_matcher_top #(
    parameter int LINE_CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input character channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_char
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [7:0] echo_char, [8] line_done,
                                        // [11:9] command, [15:12] zero
);
    import cle_pkg::*;

    cle_result_t line_result;
    cle_result_t out_result;
    logic        accept;

    // a request is taken whenever the result buffer has room
    assign accept = s_tvalid && s_tready;

    // line length, head characters and command matching
    cle_line #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_line (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .char_valid (accept),
        .rx_char    (s_tdata),
        .result     (line_result)
    );

    // result register with one spare slot for output stalls
    cle_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (line_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // pack fields from the lowest bit up, pad to whole bytes
    assign m_tdata = {{(TDATA_W - RESULT_W){1'b0}}, out_result.command,
                      out_result.line_done, out_result.echo_char};

endmodule
`default_nettype wire
